/* design/gpaa_pkg.sv */
// ----------------------------------------------------------------------------
// gpaa_pkg
// Shared widths and sideband types of the gravity pair acceleration pipeline.
// ----------------------------------------------------------------------------
package gpaa_pkg;

  localparam int ACC_W  = 48;   // Q24.24 acceleration
  localparam int POS_W  = 32;   // Q16.16 position, mass, G
  localparam int D2_W   = 65;   // squared distance, exact
  localparam int ROOT_W = 49;   // floor(sqrt(d2 * 2^32))
  localparam int MG_W   = 96;   // |offset| * G * mass
  localparam int DEN_W  = 114;  // d2 * root
  localparam int QUO_W  = 48;   // quotient bits below the cap

  // Words that ride along with the square root.
  typedef struct packed {
    logic signed [ACC_W-1:0] ax;
    logic signed [ACC_W-1:0] ay;
    logic                    negx;
    logic                    negy;
    logic                    zero;
    logic [MG_W-1:0]         mgx;
    logic [MG_W-1:0]         mgy;
    logic [D2_W-1:0]         d2;
  } gpaa_sq_side_t;

  // Words that ride along with one divider lane.
  typedef struct packed {
    logic signed [ACC_W-1:0] acc;
    logic                    neg;
    logic                    zero;
  } gpaa_lane_side_t;

endpackage

/* design/gpaa_sqrt_pipe.sv */
// ----------------------------------------------------------------------------
// gpaa_sqrt_pipe
// Pipelined restoring square root of d2 * 2^32, one root bit per stage.
// ----------------------------------------------------------------------------
module gpaa_sqrt_pipe (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  gpaa_pkg::gpaa_sq_side_t in_side,
  output logic                   out_valid,
  output logic [gpaa_pkg::ROOT_W-1:0] out_root,
  output gpaa_pkg::gpaa_sq_side_t out_side
);
  import gpaa_pkg::*;

  localparam int NST   = ROOT_W;
  localparam int REM_W = ROOT_W + 2;

  logic                vld  [1:NST];
  logic [REM_W-1:0]    rem  [1:NST];
  logic [ROOT_W-1:0]   root [1:NST];
  gpaa_sq_side_t       side [1:NST];

  for (genvar k = 0; k < NST; k++) begin : g_stage
    logic              cur_v;
    logic [REM_W-1:0]  cur_rem;
    logic [ROOT_W-1:0] cur_root;
    gpaa_sq_side_t     cur_side;
    logic [1:0]        pair;
    logic [D2_W:0]     rad;
    logic [REM_W-1:0]  r_t;
    logic [REM_W-1:0]  trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign cur_v    = in_valid;
      assign cur_rem  = '0;
      assign cur_root = '0;
      assign cur_side = in_side;
    end else begin : g_next
      assign cur_v    = vld[k];
      assign cur_rem  = rem[k];
      assign cur_root = root[k];
      assign cur_side = side[k];
    end

    assign rad = {1'b0, cur_side.d2};

    // radicand pairs come from d2; the low 32 bits of the radicand are zero
    if (k < (D2_W + 1) / 2) begin : g_pair
      assign pair = rad[D2_W - 2*k -: 2];
    end else begin : g_zpair
      assign pair = 2'b00;
    end

    assign r_t   = {cur_rem[REM_W-3:0], pair};
    assign trial = {cur_root, 2'b01};
    assign ge    = (r_t >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= cur_v;
      end
      rem[k+1]  <= ge ? (r_t - trial) : r_t;
      root[k+1] <= {cur_root[ROOT_W-2:0], ge};
      side[k+1] <= cur_side;
    end
  end

  assign out_valid = vld[NST];
  assign out_root  = root[NST];
  assign out_side  = side[NST];

endmodule

/* design/gpaa_div_pipe.sv */
// ----------------------------------------------------------------------------
// gpaa_div_pipe
// One divider lane: floor(mg * 2^40 / den), capped at 2^48, one bit a stage.
// ----------------------------------------------------------------------------
module gpaa_div_pipe (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [gpaa_pkg::MG_W-1:0]  mg,
  input  logic [gpaa_pkg::DEN_W-1:0] den,
  input  gpaa_pkg::gpaa_lane_side_t  in_side,
  output logic                       out_valid,
  output logic [gpaa_pkg::QUO_W:0]   quo,
  output gpaa_pkg::gpaa_lane_side_t  out_side
);
  import gpaa_pkg::*;

  localparam int NST = QUO_W;
  localparam int LOW = 8;   // mg bits shifted in after the start word

  logic              vld  [0:NST];
  logic              cap  [0:NST];
  logic [DEN_W-1:0]  rem  [0:NST];
  logic [DEN_W-1:0]  dv   [0:NST];
  logic [LOW-1:0]    lo8  [0:NST];
  logic [QUO_W-1:0]  q    [0:NST];
  gpaa_lane_side_t   side [0:NST];

  // prep: cap check and start remainder
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
    cap[0]  <= ({{(DEN_W + LOW - MG_W){1'b0}}, mg} >= {den, 8'd0});
    rem[0]  <= {{(DEN_W - MG_W + LOW){1'b0}}, mg[MG_W-1:LOW]};
    dv[0]   <= den;
    lo8[0]  <= mg[LOW-1:0];
    q[0]    <= '0;
    side[0] <= in_side;
  end

  for (genvar k = 0; k < NST; k++) begin : g_stage
    logic             nbit;
    logic [DEN_W:0]   r_t;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (k < LOW) begin : g_bit
      assign nbit = lo8[k][LOW-1-k];
    end else begin : g_zbit
      assign nbit = 1'b0;
    end

    assign r_t  = {rem[k], nbit};
    assign ge   = (r_t >= {1'b0, dv[k]});
    assign diff = r_t - {1'b0, dv[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
      cap[k+1]  <= cap[k];
      rem[k+1]  <= ge ? diff[DEN_W-1:0] : r_t[DEN_W-1:0];
      dv[k+1]   <= dv[k];
      lo8[k+1]  <= lo8[k];
      q[k+1]    <= {q[k][QUO_W-2:0], ge};
      side[k+1] <= side[k];
    end
  end

  assign out_valid = vld[NST];
  assign quo       = cap[NST] ? {1'b1, {QUO_W{1'b0}}} : {1'b0, q[NST]};
  assign out_side  = side[NST];

endmodule

/* design/gravity_pair_accel_accumulate.sv */
// ----------------------------------------------------------------------------
// gravity_pair_accel_accumulate
// Adds the planar pull G*m*(p-b)/|p-b|^3 of one mass point to a body's
// running acceleration, with saturation and a coincident-position flag.
// ----------------------------------------------------------------------------
// One word is taken in every clock cycle: busy is low except during reset.
// Each word comes out strobed by done for a single cycle, in order; the
// receiver has no back pressure. The path runs through the 49-stage square
// root and the 48-bit quotient, each of which resolves one bit per stage,
// plus nine stages of subtract, multiply, divider setup and final add
// around them. When positions coincide the running acceleration passes
// through, zero_distance is set and saturated stays low.
// ----------------------------------------------------------------------------
module gravity_pair_accel_accumulate (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [31:0]         cfg_wr_data,
  input  logic                start,
  output logic                busy,
  input  logic signed [31:0]  body_x,
  input  logic signed [31:0]  body_y,
  input  logic signed [47:0]  accel_x_in,
  input  logic signed [47:0]  accel_y_in,
  input  logic signed [31:0]  point_x,
  input  logic signed [31:0]  point_y,
  input  logic [31:0]         point_mass,
  output logic                done,
  output logic signed [47:0]  accel_x_out,
  output logic signed [47:0]  accel_y_out,
  output logic                zero_distance,
  output logic                saturated
);
  import gpaa_pkg::*;

  localparam int SUM_W = ACC_W + 3;
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  logic [POS_W-1:0] grav_constant;

  // G register; the user must write it only while the pipe is empty, the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      grav_constant <= 32'd65536;
    end else if (cfg_wr_en) begin
      grav_constant <= cfg_wr_data;
    end
  end

  // never stall; hold off only while reset clears the valid chain
  assign busy = rst;

  // ---- stage 1: offsets and magnitudes
  logic signed [POS_W:0] dx, dy;
  logic [POS_W:0]        dxm, dym;

  assign dx  = {point_x[POS_W-1], point_x} - {body_x[POS_W-1], body_x};
  assign dy  = {point_y[POS_W-1], point_y} - {body_y[POS_W-1], body_y};
  assign dxm = dx[POS_W] ? -dx : dx;
  assign dym = dy[POS_W] ? -dy : dy;

  logic v1, v2, v3, v4, v5, v6, v7;
  logic [POS_W-1:0] mx1, my1, mass1, mass2;
  logic signed [ACC_W-1:0] ax1, ay1, ax2, ay2, ax3, ay3;
  logic negx1, negy1, negx2, negy2, negx3, negy3;
  logic [63:0] sqx2, sqy2, mgx2, mgy2;
  logic [63:0] mgxl3, mgxh3, mgyl3, mgyh3;
  logic [D2_W-1:0] d2_3;
  gpaa_sq_side_t side4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= start && !busy;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
    // stage 1
    mx1   <= dxm[POS_W-1:0];
    my1   <= dym[POS_W-1:0];
    negx1 <= dx[POS_W];
    negy1 <= dy[POS_W];
    ax1   <= accel_x_in;
    ay1   <= accel_y_in;
    mass1 <= point_mass;
    // stage 2: squares and |d| * G
    sqx2  <= mx1 * mx1;
    sqy2  <= my1 * my1;
    mgx2  <= mx1 * grav_constant;
    mgy2  <= my1 * grav_constant;
    ax2   <= ax1;
    ay2   <= ay1;
    negx2 <= negx1;
    negy2 <= negy1;
    mass2 <= mass1;
    // stage 3: d2 and mass partial products
    d2_3  <= {1'b0, sqx2} + {1'b0, sqy2};
    mgxl3 <= mgx2[31:0] * mass2;
    mgxh3 <= mgx2[63:32] * mass2;
    mgyl3 <= mgy2[31:0] * mass2;
    mgyh3 <= mgy2[63:32] * mass2;
    ax3   <= ax2;
    ay3   <= ay2;
    negx3 <= negx2;
    negy3 <= negy2;
    // stage 4: full |d|*G*m and the zero test
    side4.mgx  <= {32'd0, mgxl3} + {mgxh3, 32'd0};
    side4.mgy  <= {32'd0, mgyl3} + {mgyh3, 32'd0};
    side4.d2   <= d2_3;
    side4.zero <= (d2_3 == '0);
    side4.ax   <= ax3;
    side4.ay   <= ay3;
    side4.negx <= negx3;
    side4.negy <= negy3;
  end

  // ---- square root of d2 * 2^32
  logic              sq_valid;
  logic [ROOT_W-1:0] sq_root;
  gpaa_sq_side_t     sq_side;

  gpaa_sqrt_pipe u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v4),
    .in_side   (side4),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // ---- stages 5..7: den = d2 * root from four partial products
  logic [63:0] p0;
  logic [48:0] p1;
  logic [64:0] p2;
  logic [49:0] p3;
  logic [80:0] lo6;
  logic [81:0] hi6;
  logic [DEN_W-1:0] den7;
  gpaa_sq_side_t side5, side6, side7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      v5 <= sq_valid;
      v6 <= v5;
      v7 <= v6;
    end
    p0    <= sq_side.d2[31:0]  * sq_root[31:0];
    p1    <= sq_side.d2[31:0]  * sq_root[48:32];
    p2    <= sq_side.d2[64:32] * sq_root[31:0];
    p3    <= sq_side.d2[64:32] * sq_root[48:32];
    side5 <= sq_side;
    lo6   <= {17'd0, p0} + {p1, 32'd0};
    hi6   <= {17'd0, p2} + {p3, 32'd0};
    side6 <= side5;
    den7  <= {33'd0, lo6} + {hi6, 32'd0};
    side7 <= side6;
  end

  // ---- divider lanes
  gpaa_lane_side_t lx_in, ly_in, lx_out, ly_out;
  logic            lx_valid, ly_valid;
  logic [QUO_W:0]  qx, qy;

  assign lx_in = '{acc: side7.ax, neg: side7.negx, zero: side7.zero};
  assign ly_in = '{acc: side7.ay, neg: side7.negy, zero: side7.zero};

  gpaa_div_pipe u_div_x (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v7),
    .mg        (side7.mgx),
    .den       (den7),
    .in_side   (lx_in),
    .out_valid (lx_valid),
    .quo       (qx),
    .out_side  (lx_out)
  );

  gpaa_div_pipe u_div_y (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v7),
    .mg        (side7.mgy),
    .den       (den7),
    .in_side   (ly_in),
    .out_valid (ly_valid),
    .quo       (qy),
    .out_side  (ly_out)
  );

  // ---- final add and clamp
  logic signed [SUM_W-1:0] cx, cy, sx, sy;
  logic hix, lox, hiy, loy;

  assign cx  = lx_out.neg ? -$signed({2'b00, qx}) : $signed({2'b00, qx});
  assign cy  = ly_out.neg ? -$signed({2'b00, qy}) : $signed({2'b00, qy});
  assign sx  = {{(SUM_W-ACC_W){lx_out.acc[ACC_W-1]}}, lx_out.acc} + cx;
  assign sy  = {{(SUM_W-ACC_W){ly_out.acc[ACC_W-1]}}, ly_out.acc} + cy;
  assign hix = (sx > $signed({{(SUM_W-ACC_W){1'b0}}, ACC_MAX}));
  assign lox = (sx < $signed({{(SUM_W-ACC_W){1'b1}}, ACC_MIN}));
  assign hiy = (sy > $signed({{(SUM_W-ACC_W){1'b0}}, ACC_MAX}));
  assign loy = (sy < $signed({{(SUM_W-ACC_W){1'b1}}, ACC_MIN}));

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= lx_valid && ly_valid;
    end
    if (lx_out.zero) begin
      // coincident: pass the running acceleration through
      accel_x_out   <= lx_out.acc;
      accel_y_out   <= ly_out.acc;
      zero_distance <= 1'b1;
      saturated     <= 1'b0;
    end else begin
      accel_x_out   <= hix ? ACC_MAX : (lox ? ACC_MIN : sx[ACC_W-1:0]);
      accel_y_out   <= hiy ? ACC_MAX : (loy ? ACC_MIN : sy[ACC_W-1:0]);
      zero_distance <= 1'b0;
      saturated     <= hix || lox || hiy || loy;
    end
  end

`ifndef SYNTHESIS
  // both lanes run in lockstep
  a_lane_lockstep: assert property (@(posedge clk) disable iff (rst)
    lx_valid == ly_valid) else $error("divider lanes out of step");

  // a coincident word never reports saturation
  a_zero_no_sat: assert property (@(posedge clk) disable iff (rst)
    done && zero_distance |-> !saturated) else $error("zero distance with saturation");

  // saturation leaves at least one component on a bound
  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    done && saturated |-> (accel_x_out == ACC_MAX || accel_x_out == ACC_MIN ||
                           accel_y_out == ACC_MAX || accel_y_out == ACC_MIN))
    else $error("saturated without clamped output");

  // reset empties the pipe
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !done) else $error("done right after reset");
`endif

endmodule
